@@ rtl/core/sliding_window_send_buffer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window send buffer
// Clocked, reset-gated property helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SEND_BUFFER_ASSERT_SVH
`define SLIDING_WINDOW_SEND_BUFFER_ASSERT_SVH

// Same-cycle implication
`define SWSB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SWSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/swsb_pkg.sv @@
// ----------------------------------------------------------------------------
// swsb_pkg
// Shared types, command and error codes for the sliding window send buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swsb_pkg;

    localparam int DEF_WINDOW_SLOTS = 32;
    localparam int DEF_HANDLE_BITS  = 16;

    // item payload widths
    localparam int CMD_W    = 3;
    localparam int SEQ_W    = 8;
    localparam int HDL_W    = 16;
    localparam int SLOT_W   = 5;
    localparam int ERR_W    = 2;
    localparam int OCC_W    = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ACK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    localparam logic [SEQ_W-1:0] ACK_DISTANCE = 8'd100;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture input item
        logic issue;  // first slot read
        logic check;  // evaluate read data
        logic post;   // move result to output register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stop;   // command finished this check cycle
    } t_dp_status;

endpackage

@@ rtl/core/swsb_ram.sv @@
// ----------------------------------------------------------------------------
// swsb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/swsb_ctrl.sv @@
// ----------------------------------------------------------------------------
// swsb_ctrl
// Command sequencer: accept, first read, check loop, result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_send_buffer_assert.svh"

module swsb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output swsb_pkg::t_ctl_cmd   o_cmd,
    input  swsb_pkg::t_dp_status i_sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.stop) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // output register free or draining this cycle
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.post = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.post) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    `SWSB_ASSERT_NEXT(a_done_posts, i_clk, i_rst_n, (r_state == ST_DONE) && !r_out_valid, r_out_valid && (r_state == ST_IDLE), "finished result not posted to free output")

endmodule

@@ rtl/core/swsb_dp.sv @@
// ----------------------------------------------------------------------------
// swsb_dp
// Ring state, slot storage, ack compare, search walk and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_send_buffer_assert.svh"

module swsb_dp #(
    parameter int WINDOW_SLOTS = swsb_pkg::DEF_WINDOW_SLOTS,
    parameter int HANDLE_BITS  = swsb_pkg::DEF_HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swsb_pkg::t_ctl_cmd            i_cmd,
    output swsb_pkg::t_dp_status          o_sts,
    input  logic [swsb_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic [swsb_pkg::M_DATA_W-1:0] o_m_tdata
);

    localparam int SW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam int RW = swsb_pkg::SEQ_W + HANDLE_BITS;
    localparam int RES_W = 1 + swsb_pkg::ERR_W + swsb_pkg::HDL_W + swsb_pkg::SEQ_W
                         + swsb_pkg::SLOT_W + swsb_pkg::OCC_W;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] i);
        f_next = (i == SW'(WINDOW_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic f_ack_covers(input logic [7:0] a, input logic [7:0] r);
        logic [7:0] d_ra;
        logic [7:0] d_ar;
        d_ra = r - a;
        d_ar = a - r;
        if (a < r && d_ra > swsb_pkg::ACK_DISTANCE) begin
            f_ack_covers = 1'b1;
        end else if (r < a && d_ar > swsb_pkg::ACK_DISTANCE) begin
            f_ack_covers = 1'b0;
        end else begin
            f_ack_covers = (a >= r);
        end
    endfunction

    // input fields
    logic [swsb_pkg::CMD_W-1:0]  in_cmd;
    logic [swsb_pkg::SEQ_W-1:0]  in_seq;
    logic [swsb_pkg::HDL_W-1:0]  in_handle;
    logic                        in_from_head;
    logic [swsb_pkg::SLOT_W-1:0] in_start;
    logic [SW-1:0]               start_mod;

    assign in_cmd       = i_s_tdata[2:0];
    assign in_seq       = i_s_tdata[10:3];
    assign in_handle    = i_s_tdata[26:11];
    assign in_from_head = i_s_tdata[27];
    assign in_start     = i_s_tdata[32:28];

    // start slot modulo ring size, small table
    always_comb begin
        start_mod = '0;
        for (int i = 0; i < 32; i++) begin
            if (in_start == 5'(i)) begin
                start_mod = SW'(i % WINDOW_SLOTS);
            end
        end
    end

    // ring state
    logic [WINDOW_SLOTS-1:0] r_valid, n_valid;
    logic [SW-1:0]           r_head, n_head;
    logic [SW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_fill, n_fill;

    // captured item and walk pointers
    logic [swsb_pkg::CMD_W-1:0] r_cmd;
    logic [swsb_pkg::SEQ_W-1:0] r_seq;
    logic [swsb_pkg::HDL_W-1:0] r_handle;
    logic [SW-1:0]              r_idx;
    logic [SW-1:0]              r_chk;
    logic                       r_first;

    logic [RES_W-1:0] r_res, n_res;
    logic [RES_W-1:0] r_out;

    // slot storage
    logic          ram_we;
    logic [RW-1:0] ram_wdata;
    logic [RW-1:0] ram_rdata;
    logic [swsb_pkg::SEQ_W-1:0]  rd_seq;
    logic [HANDLE_BITS-1:0]      rd_handle;

    assign ram_wdata = {r_seq, HANDLE_BITS'(r_handle)};
    assign rd_seq    = ram_rdata[RW-1 -: swsb_pkg::SEQ_W];
    assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

    swsb_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // command evaluation on the check cycle
    logic                        res_hit;
    logic [swsb_pkg::ERR_W-1:0]  res_err;
    logic [swsb_pkg::HDL_W-1:0]  res_handle;
    logic [swsb_pkg::SEQ_W-1:0]  res_seq;
    logic [swsb_pkg::SLOT_W-1:0] res_next;
    logic                        stop;
    logic                        full;
    logic                        empty;

    assign full  = (r_fill == CW'(WINDOW_SLOTS));
    assign empty = (r_fill == '0);

    always_comb begin
        res_hit    = 1'b0;
        res_err    = swsb_pkg::ERR_NONE;
        res_handle = '0;
        res_seq    = '0;
        res_next   = '0;
        stop       = 1'b1;
        ram_we     = 1'b0;
        n_valid    = r_valid;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        case (r_cmd)
            swsb_pkg::CMD_ADD: begin
                if (full) begin
                    res_err = swsb_pkg::ERR_FULL;
                end else begin
                    ram_we          = i_cmd.check;
                    n_valid[r_tail] = 1'b1;
                    n_tail          = f_next(r_tail);
                    n_fill          = r_fill + 1'b1;
                end
            end
            swsb_pkg::CMD_POP: begin
                if (empty) begin
                    res_err = swsb_pkg::ERR_EMPTY;
                end else begin
                    n_valid[r_head] = 1'b0;
                    n_head          = f_next(r_head);
                    n_fill          = r_fill - 1'b1;
                end
            end
            swsb_pkg::CMD_PEEK: begin
                if (!empty) begin
                    res_hit    = 1'b1;
                    res_handle = swsb_pkg::HDL_W'(rd_handle);
                    res_seq    = rd_seq;
                end
            end
            swsb_pkg::CMD_ACK: begin
                if (!empty) begin
                    res_hit    = f_ack_covers(r_seq, rd_seq);
                    res_handle = swsb_pkg::HDL_W'(rd_handle);
                    res_seq    = rd_seq;
                end
            end
            swsb_pkg::CMD_SEARCH: begin
                if (!r_valid[r_chk]) begin
                    stop = 1'b1;
                end else if (rd_seq == r_seq) begin
                    res_hit    = 1'b1;
                    res_handle = swsb_pkg::HDL_W'(rd_handle);
                    res_seq    = rd_seq;
                    res_next   = swsb_pkg::SLOT_W'(f_next(r_chk));
                end else if (!r_first && r_chk == r_head) begin
                    stop = 1'b1;   // wrapped back to head
                end else begin
                    stop = 1'b0;
                end
            end
            default: begin
                stop = 1'b1;
            end
        endcase
    end

    assign n_res = {swsb_pkg::OCC_W'(n_fill), res_next, res_seq, res_handle, res_err, res_hit};
    assign o_sts.stop = stop;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
        end else if (i_cmd.check && stop) begin
            r_valid <= n_valid;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= in_cmd;
            r_seq    <= in_seq;
            r_handle <= in_handle;
            if (in_cmd == swsb_pkg::CMD_SEARCH && !in_from_head) begin
                r_idx <= start_mod;
            end else begin
                r_idx <= r_head;
            end
        end else if (i_cmd.issue || (i_cmd.check && !stop)) begin
            // read of r_idx lands next cycle, tracked by r_chk
            r_chk <= r_idx;
            r_idx <= f_next(r_idx);
        end
        if (i_cmd.issue) begin
            r_first <= 1'b1;
        end else if (i_cmd.check) begin
            r_first <= 1'b0;
        end
        if (i_cmd.check && stop) begin
            r_res <= n_res;
        end
        if (i_cmd.post) begin
            r_out <= r_res;
        end
    end

    assign o_m_tdata = swsb_pkg::M_DATA_W'(r_out);

    `SWSB_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(WINDOW_SLOTS), "fill count beyond ring size")
    `SWSB_ASSERT_NOW(a_fill_marks, i_clk, i_rst_n, 1'b1, $countones(r_valid) == int'(r_fill), "fill count disagrees with valid marks")
    `SWSB_ASSERT_NOW(a_head_valid, i_clk, i_rst_n, r_fill != '0, r_valid[r_head], "nonempty ring with empty head slot")

endmodule

@@ rtl/core/sliding_window_send_buffer.sv @@
// Add, pop, peek, ack check: accept, ISSUE, one CHECK, DONE, then result valid.
// Search: one CHECK per slot visited (1 to WINDOW_SLOTS + 1), one slot per cycle.
// Throughput: one item in flight; next accept the cycle after the result is posted.
// The single read port of the slot RAM sets the one-slot-per-cycle search walk.
// Reset (i_rst_n low, synchronous): valid marks, head, tail, fill, FSM cleared.
// Slot contents are not cleared; only slots marked valid are ever read.
// ----------------------------------------------------------------------------
// sliding_window_send_buffer
// Ring buffer of in-flight packets (sequence number + handle) with add, pop,
// peek, ack check and forward search commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_send_buffer #(
    parameter int WINDOW_SLOTS = swsb_pkg::DEF_WINDOW_SLOTS,  // 2 .. 32
    parameter int HANDLE_BITS  = swsb_pkg::DEF_HANDLE_BITS    // 1 .. 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] command, [10:3] seq_number, [26:11] packet_handle,
    // [27] from_head, [32:28] start_slot, [39:33] zero
    input  logic [swsb_pkg::S_DATA_W-1:0] s_axis_tdata,
    // result item
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] hit, [2:1] error_code, [18:3] found_handle, [26:19] found_seq,
    // [31:27] next_slot, [37:32] occupancy, [39:38] zero
    output logic [swsb_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // Controller walks IDLE -> ISSUE -> CHECK (repeats while a search walks)
    // -> DONE. The datapath evaluates the command on every CHECK cycle using
    // the registered RAM read issued the cycle before, and reports stop.
    // State updates (add write, pop release) commit on the stopping check.
    // The finished result waits in DONE until the output register is free,
    // so a result held by the downstream side never blocks the next accept
    // beyond the one being built.

    swsb_pkg::t_ctl_cmd   ctl_cmd;
    swsb_pkg::t_dp_status dp_sts;

    swsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (ctl_cmd),
        .i_sts      (dp_sts)
    );

    swsb_dp #(
        .WINDOW_SLOTS (WINDOW_SLOTS),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ctl_cmd),
        .o_sts     (dp_sts),
        .i_s_tdata (s_axis_tdata),
        .o_m_tdata (m_axis_tdata)
    );

endmodule
